@@ hw/rtl/sud_pkg.sv @@
// ----------------------------------------------------------------------------
// sud_pkg
// Shared constants for the signed/unsigned divider: field widths, default
// datapath width and operation codes.
// ----------------------------------------------------------------------------
package sud_pkg;

    localparam int FIELD_W        = 32;
    localparam int OP_W           = 2;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
    localparam logic [OP_W-1:0] OP_UREM = 2'd1;
    localparam logic [OP_W-1:0] OP_SQUO = 2'd2;
    localparam logic [OP_W-1:0] OP_SREM = 2'd3;

endpackage

@@ hw/rtl/sud_sub_unit.sv @@
// ----------------------------------------------------------------------------
// sud_sub_unit
// Shared subtractor: a - b with borrow out. Serves the restoring divide steps
// and every two's complement negation (a = 0).
// ----------------------------------------------------------------------------
module sud_sub_unit #(
    parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH_DEF
) (
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [DATA_WIDTH-1:0] o_diff,
    output logic                  o_borrow
);

    logic [DATA_WIDTH:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[DATA_WIDTH-1:0];
    assign o_borrow = w_full[DATA_WIDTH];

endmodule

@@ hw/rtl/signed_unsigned_divider_top.sv @@
// ----------------------------------------------------------------------------
// signed_unsigned_divider_top
// Radix-2 restoring divider, quotient or remainder, unsigned or signed.
// Sequence: negate dividend, negate divisor, divide loop, then fix and load;
//   a zero divisor skips the divide and gives 0 from the fix step.
// One subtract step per quotient bit through the single shared subtractor;
//   a new word is accepted only once the sequencer is back in idle.
// Reset: synchronous active-low, returns the sequencer to idle and drops
//   the pending result.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_top #(
    parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sud_pkg::FIELD_W-1:0]     i_dividend,
    input  logic [sud_pkg::FIELD_W-1:0]     i_divisor,
    input  logic [sud_pkg::OP_W-1:0]        i_operation,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sud_pkg::FIELD_W-1:0]     o_result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NEGX = 5'b00010,
        S_NEGY = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIX  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [DATA_WIDTH-1:0]   r_rem, n_rem;
    logic [DATA_WIDTH-1:0]   r_quo, n_quo;
    logic [DATA_WIDTH-1:0]   r_div, n_div;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_is_rem, n_is_rem;
    logic                    r_signed, n_signed;
    logic                    r_xs, n_xs;
    logic                    r_ys, n_ys;
    logic                    r_zero, n_zero;
    logic                    r_out_valid, n_out_valid;
    logic [sud_pkg::FIELD_W-1:0] r_result, n_result;

    logic [DATA_WIDTH-1:0]   w_x, w_y;
    logic [DATA_WIDTH-1:0]   w_a, w_b, w_diff;
    logic                    w_borrow;
    logic [DATA_WIDTH-1:0]   w_shift;
    logic [DATA_WIDTH-1:0]   w_sel;
    logic                    w_take;
    logic                    w_neg_res;
    logic                    w_in_acc;
    logic                    w_out_free;

    assign w_x        = DATA_WIDTH'(i_dividend);
    assign w_y        = DATA_WIDTH'(i_divisor);
    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_result   = r_result;

    assign w_shift   = {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
    assign w_take    = r_rem[DATA_WIDTH-1] || !w_borrow;
    assign w_sel     = r_is_rem ? r_rem : r_quo;
    assign w_neg_res = r_signed && (r_is_rem ? r_xs : (r_xs != r_ys));

    // operand select for the shared subtractor
    always_comb begin
        w_a = '0;
        case (r_state)
            S_NEGX:  w_b = r_quo;
            S_NEGY:  w_b = r_div;
            S_DIV: begin
                w_a = w_shift;
                w_b = r_div;
            end
            S_FIX:   w_b = w_sel;
            default: w_b = '0;
        endcase
    end

    sud_sub_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sub (
        .i_a      (w_a),
        .i_b      (w_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_is_rem    = r_is_rem;
        n_signed    = r_signed;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_result    = r_result;

        // drop the word once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_rem    = '0;
                    n_quo    = w_x;
                    n_div    = w_y;
                    n_cnt    = CNT_W'(DATA_WIDTH - 1);
                    n_is_rem = (i_operation == sud_pkg::OP_UREM) ||
                               (i_operation == sud_pkg::OP_SREM);
                    n_signed = (i_operation == sud_pkg::OP_SQUO) ||
                               (i_operation == sud_pkg::OP_SREM);
                    n_xs     = w_x[DATA_WIDTH-1];
                    n_ys     = w_y[DATA_WIDTH-1];
                    n_zero   = (w_y == '0);
                    n_state  = (w_y == '0) ? S_FIX : S_NEGX;
                end
            end
            S_NEGX: begin
                if (r_signed && r_xs) begin
                    n_quo = w_diff;
                end
                n_state = S_NEGY;
            end
            S_NEGY: begin
                if (r_signed && r_ys) begin
                    n_div = w_diff;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_take ? w_diff : w_shift;
                n_quo = {r_quo[DATA_WIDTH-2:0], w_take};
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIX: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_zero) begin
                        n_result = '0;
                    end else if (w_neg_res) begin
                        n_result = sud_pkg::FIELD_W'(w_diff);
                    end else begin
                        n_result = sud_pkg::FIELD_W'(w_sel);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_div    <= n_div;
        r_cnt    <= n_cnt;
        r_is_rem <= n_is_rem;
        r_signed <= n_signed;
        r_xs     <= n_xs;
        r_ys     <= n_ys;
        r_zero   <= n_zero;
        r_result <= n_result;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_ready)
        else $error("divider ready right after accepting a word");

    a_load_only_in_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIX))
        else $error("result loaded outside the fix step");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_y == '0) && !r_out_valid) |=> ##1 (r_out_valid && (r_result == '0)))
        else $error("zero divisor did not give a zero result");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_NEGY) |-> (r_state == S_DIV && r_cnt == CNT_W'(DATA_WIDTH - 1)))
        else $error("divide loop did not start with a full count");

endmodule
